// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the vertical reduction filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define VFR_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define VFR_ASSERT_NEXT(name, clk, rstn, cond, cons, msg) \
  `VFR_ASSERT(name, clk, rstn, (cond) |=> (cons), msg)

`endif

// ===== rtl/core/vfr_pkg.sv =====
// Package with constants and types of the vertical reduction filter.
`default_nettype none

package vfr_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int FRAC_BITS = 12;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 13;
  localparam int PIX_W     = 8;
  localparam int COEFF_W   = 16;
  localparam int SUM_W     = 32;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = ROW_W'(4096);
  localparam logic [SUM_W-1:0] ROUND_CONST     = SUM_W'(1) << (FRAC_BITS - 1);

  // One accepted item on its way into the accumulator pipeline.
  typedef struct packed {
    logic                      valid;
    logic [COL_W-1:0]          slot;
    logic [PIX_W-1:0]          pixel;
    logic signed [COEFF_W-1:0] coeff;
    logic                      first;
    logic                      last;
    logic                      eor;
  } vfr_req_t;

  // Finished column sum leaving the accumulator pipeline.
  typedef struct packed {
    logic             valid;
    logic             eor;
    logic [SUM_W-1:0] sum;
  } vfr_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/vertical_fir_reduce_u8.sv =====
// Top level of the vertical reduction filter for 8-bit pixels.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] pixel_in, tdata[23:8] coeff, tuser[0] first_tap,
//                        tuser[1] last_tap
//   m_axis    out        tdata[7:0] pixel_out, tlast end_of_row
//   cfg       in         cfg_data_i[12:0] row_width
//
// One item is accepted per clock unless the output stalls; the result is registered.
// The rate is set by the single read and single write port of the column memory.
// Reset clears the column counter and sets row_width to 4096; sums need no clear.
// A stalled output freezes the whole pipeline and drops s_axis_tready.
`default_nettype none

module vertical_fir_reduce_u8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // pixel_in, coeff
  input  wire logic [1:0]  s_axis_tuser,  // first_tap, last_tap
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // pixel_out
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [12:0] cfg_data_i
);

`include "assert_macros.svh"

  logic [vfr_pkg::ROW_W-1:0] row_width_q;
  logic [vfr_pkg::COL_W-1:0] col_q;
  logic [vfr_pkg::COL_W-1:0] col_d;
  logic [31:0]               last_col;
  logic                      eor;
  logic                      en;
  logic                      in_acc;

  vfr_pkg::vfr_req_t req;
  vfr_pkg::vfr_res_t res;

  logic                      out_valid_q;
  logic [vfr_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_eor_q;
  logic [vfr_pkg::SUM_W-1:0] rounded;
  logic [vfr_pkg::PIX_W-1:0] pix_d;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (row_width_q == '0) begin
      last_col = '0;
    end else if (32'(row_width_q) > 32'(vfr_pkg::MAX_WIDTH)) begin
      last_col = 32'(vfr_pkg::MAX_WIDTH - 1);
    end else begin
      last_col = 32'(row_width_q) - 32'd1;
    end
    eor   = 32'(col_q) >= last_col;
    col_d = eor ? '0 : col_q + 1'b1;
  end

  always_comb begin
    req.valid = in_acc;
    req.slot  = col_q;
    req.pixel = s_axis_tdata[7:0];
    req.coeff = s_axis_tdata[23:8];
    req.first = s_axis_tuser[0];
    req.last  = s_axis_tuser[1];
    req.eor   = eor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= vfr_pkg::ROW_WIDTH_RESET;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        row_width_q <= cfg_data_i;
      end
      if (in_acc) begin
        col_q <= col_d;
      end
      if (en) begin
        out_valid_q <= res.valid;
      end
    end
  end

  vfr_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (req),
    .res_o  (res)
  );

  // Round, shift right arithmetically and clamp to the pixel range.
  always_comb begin
    rounded = res.sum + vfr_pkg::ROUND_CONST;
    if (rounded[vfr_pkg::SUM_W-1]) begin
      pix_d = '0;
    end else if (|rounded[vfr_pkg::SUM_W-2:vfr_pkg::FRAC_BITS+vfr_pkg::PIX_W]) begin
      pix_d = '1;
    end else begin
      pix_d = rounded[vfr_pkg::FRAC_BITS+vfr_pkg::PIX_W-1:vfr_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q <= pix_d;
      out_eor_q <= res.eor;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_eor_q;

  `VFR_ASSERT(a_stall_blocks_input, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken during output stall")
  `VFR_ASSERT_NEXT(a_col_wraps, clk_i, rst_ni, in_acc && eor, col_q == '0,
    "column counter did not wrap after last column")
  `VFR_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i, row_width_q == $past(cfg_data_i),
    "row width not updated by write")

endmodule

`default_nettype wire

// ===== rtl/core/vfr_acc.sv =====
// Column accumulator memory with multiply, read-modify-write and forwarding.
`default_nettype none

module vfr_acc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire vfr_pkg::vfr_req_t req_i,
  output vfr_pkg::vfr_res_t      res_o
);

  logic [vfr_pkg::SUM_W-1:0] mem [vfr_pkg::MAX_WIDTH];

  logic                          s1_valid_q;
  logic [vfr_pkg::COL_W-1:0]     s1_slot_q;
  logic [vfr_pkg::SUM_W-1:0]     s1_prod_q;
  logic                          s1_first_q;
  logic                          s1_last_q;
  logic                          s1_eor_q;
  logic                          s1_fwd_q;
  logic [vfr_pkg::SUM_W-1:0]     rdata_q;

  logic                          s2_valid_q;
  logic                          s2_last_q;
  logic                          s2_eor_q;
  logic [vfr_pkg::SUM_W-1:0]     s2_sum_q;

  logic signed [vfr_pkg::PIX_W+vfr_pkg::COEFF_W:0] prod_full;
  logic [vfr_pkg::SUM_W-1:0]     base;
  logic [vfr_pkg::SUM_W-1:0]     sum_d;

  assign prod_full = $signed({1'b0, req_i.pixel}) * req_i.coeff;

  // The previous item wrote its sum in the same cycle as this read, so it is taken
  // from the next stage instead of the memory.
  always_comb begin
    if (s1_first_q) begin
      base = '0;
    end else if (s1_fwd_q) begin
      base = s2_sum_q;
    end else begin
      base = rdata_q;
    end
    sum_d = base + s1_prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_slot_q  <= req_i.slot;
      s1_prod_q  <= vfr_pkg::SUM_W'(prod_full);
      s1_first_q <= req_i.first;
      s1_last_q  <= req_i.last;
      s1_eor_q   <= req_i.eor;
      s1_fwd_q   <= s1_valid_q && (s1_slot_q == req_i.slot);
      s2_sum_q   <= sum_d;
      s2_last_q  <= s1_last_q;
      s2_eor_q   <= s1_eor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (req_i.valid) begin
        rdata_q <= mem[req_i.slot];
      end
      if (s1_valid_q) begin
        mem[s1_slot_q] <= sum_d;
      end
    end
  end

  assign res_o.valid = s2_valid_q && s2_last_q;
  assign res_o.eor   = s2_eor_q;
  assign res_o.sum   = s2_sum_q;

endmodule

`default_nettype wire

// ===== tb/vertical_fir_checker.sv =====
// Checker that predicts the filtered pixels of the vertical reduction filter and compares them.
`default_nettype none

module vertical_fir_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // pixel_in, coeff
  input  wire logic [1:0]  s_axis_tuser,  // first_tap, last_tap
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,  // pixel_out
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [12:0] cfg_data_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [vfr_pkg::PIX_W-1:0] pixel;
    logic                      eor;
  } filtered_pixel_t;

  filtered_pixel_t            filtered_q[$];
  logic [vfr_pkg::SUM_W-1:0]  column_acc[vfr_pkg::MAX_WIDTH];
  logic [vfr_pkg::COL_W-1:0]  column_pos;
  logic [vfr_pkg::ROW_W-1:0]  line_width;

  function automatic logic [vfr_pkg::PIX_W-1:0] round_and_clamp(
      input logic [vfr_pkg::SUM_W-1:0] acc);
    logic [vfr_pkg::SUM_W-1:0] rounded;
    rounded = acc + vfr_pkg::ROUND_CONST;
    if (rounded[vfr_pkg::SUM_W-1]) return '0;
    rounded = rounded >> vfr_pkg::FRAC_BITS;
    return (rounded > 255) ? 8'd255 : rounded[vfr_pkg::PIX_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int                                 eff_width;
    logic                               row_end;
    logic [vfr_pkg::PIX_W-1:0]          pix;
    logic signed [vfr_pkg::COEFF_W-1:0] weight;
    logic signed [vfr_pkg::SUM_W-1:0]   product;
    logic [vfr_pkg::SUM_W-1:0]          acc;
    filtered_pixel_t                    want;
    if (!rst_ni) begin
      column_pos = '0;
      line_width = vfr_pkg::ROW_WIDTH_RESET;
      filtered_q.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          errors_o++;
          $display("%0t: result with nothing expected: pixel_out %0d end_of_row %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata !== want.pixel) begin
            errors_o++;
            $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, m_axis_tdata);
          end
          if (m_axis_tlast !== want.eor) begin
            errors_o++;
            $display("%0t: end_of_row expected %0b actual %0b", $time, want.eor, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pix = s_axis_tdata[7:0];
        weight = s_axis_tdata[23:8];
        eff_width = (line_width == 0) ? 1 :
                    (line_width > vfr_pkg::MAX_WIDTH) ? vfr_pkg::MAX_WIDTH : line_width;
        row_end = (int'(column_pos) >= eff_width - 1);
        product = $signed({24'd0, pix}) * $signed({{16{weight[15]}}, weight});
        acc = (s_axis_tuser[0] ? '0 : column_acc[column_pos]) + product;
        column_acc[column_pos] = acc;
        if (s_axis_tuser[1]) begin
          filtered_q.push_back('{pixel: round_and_clamp(acc), eor: row_end});
        end
        column_pos = row_end ? '0 : column_pos + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        line_width = cfg_data_i;
      end
      pending_o <= filtered_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_vertical_fir_reduce_u8.sv =====
// Testbench top that drives pixel lines and width settings into the vertical reduction filter.
`default_nettype none

module tb_vertical_fir_reduce_u8;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CALM_ITEMS   = 1600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // pixel_in, coeff
  logic [1:0]  s_axis_tuser = '0;  // first_tap, last_tap
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;  // pixel_out
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i = '0;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit idle_on = 1'b1;

  int column_pos = 0;
  int eff_width = vfr_pkg::MAX_WIDTH;
  bit column_written[vfr_pkg::MAX_WIDTH];

  int                                 line_tap;
  int                                 frame_taps;
  bit                                 long_mode;
  logic signed [vfr_pkg::COEFF_W-1:0] line_coeff;

  vertical_fir_reduce_u8 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  vertical_fir_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("vertical_fir_reduce_u8 test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_stall
    int stall_left;
    if (calm || !idle_on) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_pixel(input logic [7:0] pix, input logic signed [15:0] weight,
                            input logic first_tap, input logic last_tap);
    int gap;
    gap = (!calm && idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    // A column that was never written must restart its accumulator.
    if (!column_written[column_pos]) first_tap = 1'b1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {weight, pix};
    s_axis_tuser <= {last_tap, first_tap};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    column_written[column_pos] = 1'b1;
    column_pos = (column_pos >= eff_width - 1) ? 0 : column_pos + 1;
    items_sent++;
    if (items_sent >= CALM_ITEMS + 25) calm = 1'b1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [12:0] width);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= width;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eff_width = (width == 0) ? 1 : (width > vfr_pkg::MAX_WIDTH) ? vfr_pkg::MAX_WIDTH : width;
  endtask

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd8191;
      3:       return 13'd4096;
      4:       return 13'($urandom_range(4097, 8190));
      5:       return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(2, 48));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coeff();
    if (long_mode) return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3, 4:    return 16'($urandom);
      default: return 16'(4096 / frame_taps + $urandom_range(0, 1200) - 600);
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    if (long_mode) return $urandom_range(0, 7) == 0 ? 8'd254 : 8'd255;
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_taps();
    return long_mode ? $urandom_range(260, 320) : $urandom_range(1, 4);
  endfunction

  initial begin
    int         n;
    logic       first_tap;
    logic       last_tap;
    logic [7:0] pix;
    logic signed [15:0] weight;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_width(13'd3);
    push_pixel(8'd255, 16'sd4096, 1'b1, 1'b1);
    push_pixel(8'd0, 16'sd32767, 1'b1, 1'b1);
    push_pixel(8'd255, 16'sd32767, 1'b1, 1'b1);
    push_pixel(8'd255, -16'sd32768, 1'b1, 1'b1);
    push_pixel(8'd1, 16'sd2048, 1'b1, 1'b1);
    push_pixel(8'd1, 16'sd2047, 1'b1, 1'b1);
    repeat (3) push_pixel(8'd128, 16'sd2048, 1'b1, 1'b0);
    repeat (3) push_pixel(8'd128, 16'sd2048, 1'b0, 1'b1);
    push_pixel(8'd7, 16'sd100, 1'b1, 1'b1);
    push_pixel(8'd9, 16'sd100, 1'b1, 1'b1);
    // The counter now sits past the end of the narrower row.
    drain();
    write_width(13'd1);
    push_pixel(8'd200, 16'sd4096, 1'b1, 1'b0);
    push_pixel(8'd200, -16'sd1, 1'b0, 1'b1);
    drain();
    write_width(13'd8191);
    push_pixel(8'd77, 16'sd4096, 1'b1, 1'b1);
    push_pixel(8'd78, 16'sd4096, 1'b1, 1'b1);
    drain();
    write_width(13'd0);
    push_pixel(8'd90, 16'sd4096, 1'b1, 1'b1);
    push_pixel(8'd91, -16'sd20000, 1'b1, 1'b1);

    while (items_sent < RANDOM_ITEMS + 25) begin
      drain();
      write_width(pick_width());
      idle_on = $urandom_range(0, 3) != 0;
      long_mode = (eff_width <= 2) && ($urandom_range(0, 2) == 0);
      frame_taps = pick_taps();
      line_tap = 0;
      line_coeff = pick_coeff();
      if (long_mode) n = frame_taps * eff_width + $urandom_range(0, eff_width);
      else if (eff_width > 64) n = $urandom_range(10, 150);
      else n = eff_width * $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if (column_pos == 0 && i != 0) begin
          line_tap++;
          if (line_tap >= frame_taps) begin
            line_tap = 0;
            frame_taps = pick_taps();
          end
          line_coeff = pick_coeff();
        end
        first_tap = (line_tap == 0);
        last_tap = (line_tap == frame_taps - 1);
        pix = pick_pixel();
        weight = line_coeff;
        if (!long_mode && $urandom_range(0, 15) == 0) begin
          first_tap = $urandom_range(0, 1);
          last_tap = $urandom_range(0, 1);
          weight = 16'($urandom);
        end
        push_pixel(pix, weight, first_tap, last_tap);
      end
    end

    drain();
    if (errors == 0) begin
      $display("vertical_fir_reduce_u8 test passed");
    end else begin
      $display("vertical_fir_reduce_u8 test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== vertical_fir_reduce_u8.f =====
+incdir+rtl/core
rtl/core/vfr_pkg.sv
rtl/core/vfr_acc.sv
rtl/core/vertical_fir_reduce_u8.sv
tb/vertical_fir_checker.sv
tb/tb_vertical_fir_reduce_u8.sv
